### design/sbps_pkg.sv
// Shared types, constants and the band edge table for the band peak scaler.
// No dependencies; every other file of the block imports it.
package sbps_pkg;

  localparam int BAND_COUNT     = 16;
  localparam int BIN_LIMIT      = 256;
  localparam int BAND_W         = 4;
  localparam int BIN_W          = 8;
  localparam int VALUE_W        = 32;
  localparam int GAIN_W         = 16;
  localparam int QUEUE_DEPTH_DEF = 16;

  // register indexes of the configuration port
  localparam logic REG_LOG_MODE = 1'b0;
  localparam logic REG_GAIN     = 1'b1;

  localparam logic [GAIN_W-1:0]  GAIN_RESET = 16'd256;
  localparam logic [31:0]        LN2_Q32    = 32'd2977044472;
  localparam logic [VALUE_W-1:0] LEVEL_MAX  = 32'hFFFF_FFFF;
  // first bin index past the last band; it and later bins are ignored
  localparam logic [BIN_W-1:0]   BIN_STOP   = 8'd255;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [VALUE_W-1:0] peak;
  } band_rec_t;

  // first bin of band idx; idx 16 closes the last band
  function automatic logic [BIN_W-1:0] band_edge(input logic [BAND_W:0] idx);
    logic [BIN_W-1:0] r;
    unique case (idx)
      5'd0:  r = 8'd0;
      5'd1:  r = 8'd1;
      5'd2:  r = 8'd2;
      5'd3:  r = 8'd3;
      5'd4:  r = 8'd5;
      5'd5:  r = 8'd7;
      5'd6:  r = 8'd10;
      5'd7:  r = 8'd14;
      5'd8:  r = 8'd20;
      5'd9:  r = 8'd28;
      5'd10: r = 8'd40;
      5'd11: r = 8'd54;
      5'd12: r = 8'd74;
      5'd13: r = 8'd101;
      5'd14: r = 8'd137;
      5'd15: r = 8'd187;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

endpackage

### design/sbps_front.sv
// Front end: takes bins, tracks the running band peak and pushes a
// record for every completed band. Depends on sbps_pkg.
module sbps_front
  import sbps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output band_rec_t          push_rec
);

  logic [VALUE_W-1:0] band_peak;
  logic [BIN_W-1:0]   bin_count;
  logic [BAND_W-1:0]  current_band;

  logic               accept;
  logic               in_range;
  logic [VALUE_W-1:0] peak_next;
  logic               band_end;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign in_range  = bin_count < BIN_STOP;
  assign peak_next = (in_value > band_peak) ? in_value : band_peak;
  assign band_end  = ({1'b0, bin_count} + 9'd1) >=
                     {1'b0, band_edge({1'b0, current_band} + 5'd1)};

  assign push          = accept && in_range && band_end;
  assign push_rec.band = current_band;
  assign push_rec.peak = peak_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_peak    <= '0;
      bin_count    <= '0;
      current_band <= '0;
    end else if (accept) begin
      // the flagged bin may still close a band (push above), then all restarts
      if (in_last) begin
        band_peak    <= '0;
        bin_count    <= '0;
        current_band <= '0;
      end else if (in_range) begin
        if (band_end) begin
          band_peak    <= '0;
          current_band <= current_band + 4'd1;
        end else begin
          band_peak <= peak_next;
        end
        bin_count <= bin_count + 8'd1;
      end
    end
  end

endmodule

### design/sbps_queue.sv
// Small register queue of completed band records between front and back.
// Depends on sbps_pkg.
module sbps_queue
  import sbps_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  band_rec_t push_rec,
  output logic      full,
  input  logic      pop,
  output logic      avail,
  output band_rec_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  band_rec_t      slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == FULL_CNT;
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### design/sbps_back.sv
// Back end: scales one band peak at a time (log2 by normalize and repeated
// squaring, or linear by a reciprocal multiply for the divide by five).
// Depends on sbps_pkg.
module sbps_back
  import sbps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               log_mode,
  input  logic [GAIN_W-1:0]  gain,
  input  logic               q_avail,
  input  band_rec_t          q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BAND_W-1:0]  out_band,
  output logic [VALUE_W-1:0] out_level,
  output logic               out_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_LIN, S_LINSAT, S_DIV, S_FIX, S_NORM, S_SQR, S_LN, S_GAIN
  } state_t;

  localparam logic [39:0] DIV_SAT    = 40'h5_0000_0000;
  localparam logic [4:0]  DIVISOR    = 5'd5;
  // 0.6 in Q0.32, truncated; y/5 is about (y>>3) * (1 + 0.6)
  localparam logic [31:0] RECIP_FRAC = 32'h9999_9999;

  state_t             state;
  logic               done;
  logic [BAND_W-1:0]  band;
  logic [VALUE_W-1:0] peak;
  logic [VALUE_W-1:0] level;
  logic [47:0]        prod;
  logic [4:0]         rem;
  logic [31:0]        sh;
  logic [31:0]        qest;
  logic [31:0]        m;
  logic [4:0]         e;
  logic [15:0]        frac;
  logic [4:0]         cnt;
  logic [19:0]        lnq;

  logic [49:0] prod3;
  logic [39:0] y;
  logic [63:0] qprod;
  logic [4:0]  qrem;
  logic [63:0] sq;
  logic [32:0] sqt;
  logic [19:0] lval;
  logic [51:0] lnprod;
  logic [35:0] gprod;

  assign prod3  = {2'b00, prod} + {1'b0, prod, 1'b0};
  assign y      = prod3[49:10];
  assign qprod  = {32'd0, sh} * {32'd0, RECIP_FRAC};
  // remainder y - 5*qest is below 15, so its low five bits are exact
  assign qrem   = rem - 5'(qest[4:0] * DIVISOR);
  assign sq     = {32'd0, m} * {32'd0, m};
  assign sqt    = sq[63:31];
  assign lval   = {e[3:0], frac};
  assign lnprod = {32'd0, lval} * {20'd0, LN2_Q32};
  assign gprod  = {20'd0, gain} * {16'd0, lnq};

  assign pop = (state == S_IDLE) && !done && q_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // hand a finished level to the output register once it is free
      if (done && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        out_band  <= band;
        out_level <= level;
        out_last  <= band == BAND_W'(BAND_COUNT - 1);
        done      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            band <= q_head.band;
            peak <= q_head.peak;
            if (q_head.peak == '0) begin
              level <= '0;
              done  <= 1'b1;
            end else if (log_mode) begin
              m     <= q_head.peak;
              e     <= 5'd31;
              cnt   <= '0;
              state <= S_NORM;
            end else begin
              state <= S_LIN;
            end
          end
        end
        S_LIN: begin
          prod  <= {16'd0, gain} * {16'd0, peak};
          state <= S_LINSAT;
        end
        S_LINSAT: begin
          if (y >= DIV_SAT) begin
            level <= LEVEL_MAX;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            rem   <= y[4:0];
            sh    <= y[34:3];
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // estimate is at most two below the true quotient
          qest  <= sh + qprod[63:32];
          state <= S_FIX;
        end
        S_FIX: begin
          level <= qest + ((qrem >= 5'd10) ? 32'd2 : ((qrem >= DIVISOR) ? 32'd1 : 32'd0));
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_NORM: begin
          // binary search for the leading one, halving the shift each step
          unique case (cnt[2:0])
            3'd0: if (m[31:16] == '0) begin m <= {m[15:0], 16'd0}; e <= e - 5'd16; end
            3'd1: if (m[31:24] == '0) begin m <= {m[23:0], 8'd0};  e <= e - 5'd8;  end
            3'd2: if (m[31:28] == '0) begin m <= {m[27:0], 4'd0};  e <= e - 5'd4;  end
            3'd3: if (m[31:30] == '0) begin m <= {m[29:0], 2'd0};  e <= e - 5'd2;  end
            default: if (!m[31]) begin m <= {m[30:0], 1'b0}; e <= e - 5'd1; end
          endcase
          if (cnt == 5'd4) begin
            cnt   <= '0;
            frac  <= '0;
            state <= S_SQR;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SQR: begin
          frac <= {frac[14:0], sqt[32]};
          m    <= sqt[32] ? sqt[32:1] : sqt[31:0];
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= S_LN;
          end
        end
        S_LN: begin
          // log2 at or below zero (peak up to 1.0) gives level 0
          if (!e[4] || (e[3:0] == '0 && frac == '0)) begin
            level <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            lnq   <= lnprod[51:32];
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          level <= {4'd0, gprod[35:8]};
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### design/spectrum_band_peak_scaler.sv
// Top level of the band peak scaler: config registers, front end, queue and
// scaling back end. Depends on sbps_pkg, sbps_front, sbps_queue, sbps_back.
//
// Usage:
//   s_axis carries one FFT bin per item (tdata = bin_value, Q16.16) with
//   tlast on the final bin of a frame. Bins 0..254 are grouped into 16 bands;
//   later bins are ignored. tlast restarts the bin count and drops any
//   partial band.
//   m_axis carries one item per completed band: tdata holds band_number and
//   band_level (Q16.16), tlast marks band 15.
//   cfg_we/cfg_addr/cfg_wdata write log_mode (index 0) and gain (index 1,
//   Q8.8); write them only while the block is idle.
// Timing:
//   s_axis takes one bin per cycle while the band queue has room. The back
//   end scales one band at a time: in log mode by pop, 5 normalize steps,
//   16 squarings on one 32x32 multiplier, ln 2 and gain multiplies and
//   hand-off, skipping both multiplies when the log clamps to 0; in linear
//   mode by pop, gain multiply, saturation check, reciprocal multiply,
//   remainder fix and hand-off, ending after the check when it saturates;
//   a zero peak goes straight from pop to hand-off.
// Reset clears the band tracking, the queue and the output valid, and sets
//   log_mode=1, gain=1.0. A stalled m_axis holds its item; the back end then
//   waits with its next result and the queue absorbs bands until full, at
//   which point s_axis_tready drops.
module spectrum_band_peak_scaler
  import sbps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] bin_value
  input  logic        s_axis_tlast,   // last_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] band_number, [35:4] band_level, zero pad
  output logic        m_axis_tlast,   // last_band
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic              log_mode;
  logic [GAIN_W-1:0] gain;

  logic      q_full;
  logic      q_avail;
  logic      push;
  logic      pop;
  band_rec_t push_rec;
  band_rec_t q_head;

  logic [BAND_W-1:0]  out_band;
  logic [VALUE_W-1:0] out_level;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log_mode <= 1'b1;
      gain     <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LOG_MODE: log_mode <= cfg_wdata[0];
        REG_GAIN:     gain     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  sbps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_value (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  sbps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  sbps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .log_mode  (log_mode),
    .gain      (gain),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_band  (out_band),
    .out_level (out_level),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_level, out_band};

endmodule

### test/sbps_band_checker.sv
`timescale 1ns / 100ps
// Band result checker for spectrum_band_peak_scaler: follows config writes and
// accepted bins, predicts each band item and compares it with m_axis.
// Depends on sbps_pkg for the register indexes and the ln 2 constant.
module sbps_band_checker
  import sbps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          bands_pending
);

  typedef struct packed {
    logic [3:0]  band;
    logic [31:0] level;
    logic        last;
  } band_item_t;

  band_item_t  levels_due[$];

  logic        log_mode_q;
  logic [15:0] gain_q;
  logic [31:0] run_peak;
  logic [7:0]  bin_idx;
  logic [3:0]  cur_band;

  // bin count that closes band b (first bin of band b+1)
  function automatic logic [8:0] band_close(input logic [3:0] b);
    logic [8:0] r;
    case (b)
      4'd0:    r = 9'd1;
      4'd1:    r = 9'd2;
      4'd2:    r = 9'd3;
      4'd3:    r = 9'd5;
      4'd4:    r = 9'd7;
      4'd5:    r = 9'd10;
      4'd6:    r = 9'd14;
      4'd7:    r = 9'd20;
      4'd8:    r = 9'd28;
      4'd9:    r = 9'd40;
      4'd10:   r = 9'd54;
      4'd11:   r = 9'd74;
      4'd12:   r = 9'd101;
      4'd13:   r = 9'd137;
      4'd14:   r = 9'd187;
      default: r = 9'd255;
    endcase
    return r;
  endfunction

  // log2(x / 2^16) as signed Q16.16, fraction by repeated squaring
  function automatic longint log2_q16(input logic [31:0] x);
    int          e;
    int          k;
    logic [63:0] m;
    logic [15:0] frac;
    e = 31;
    while (e > 0 && x[e] == 1'b0)
      e--;
    m = {32'd0, x} << (31 - e);
    frac = 16'd0;
    for (k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return longint'(e - 16) * 65536 + longint'({48'd0, frac});
  endfunction

  function automatic logic [31:0] scaled_level(input logic [31:0] peak, input logic mode,
                                               input logic [15:0] g);
    longint      l;
    logic [63:0] lu;
    logic [63:0] lnq;
    logic [63:0] v;
    if (peak == 32'd0)
      return 32'd0;
    if (mode) begin
      l = log2_q16(peak);
      if (l <= 0)
        return 32'd0;
      lu = l;
      lnq = (lu * {32'd0, LN2_Q32}) >> 32;
      v = ({48'd0, g} * lnq) >> 8;
    end else begin
      v = ({48'd0, g} * {32'd0, peak} * 64'd3) / 64'd5120;
    end
    return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // one accepted bin: update the band in progress, queue a level on band close
  task automatic track_bin(input logic [31:0] value, input logic last);
    band_item_t item;
    if (bin_idx < 8'd255) begin
      if (value > run_peak)
        run_peak = value;
      if ({1'b0, bin_idx} + 9'd1 >= band_close(cur_band)) begin
        item.band  = cur_band;
        item.level = scaled_level(run_peak, log_mode_q, gain_q);
        item.last  = (cur_band == 4'd15);
        levels_due.push_back(item);
        run_peak = 32'd0;
        cur_band = cur_band + 4'd1;
      end
      bin_idx = bin_idx + 8'd1;
    end
    if (last) begin
      run_peak = 32'd0;
      bin_idx  = 8'd0;
      cur_band = 4'd0;
    end
  endtask

  always @(posedge clk) begin : watch
    band_item_t got;
    band_item_t want;
    if (rst) begin
      log_mode_q = 1'b1;
      gain_q     = 16'd256;
      run_peak   = 32'd0;
      bin_idx    = 8'd0;
      cur_band   = 4'd0;
      levels_due.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_LOG_MODE)
          log_mode_q = cfg_wdata[0];
        else if (cfg_addr == REG_GAIN)
          gain_q = cfg_wdata;
      end
      if (s_tvalid && s_tready)
        track_bin(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        got.band  = m_tdata[3:0];
        got.level = m_tdata[35:4];
        got.last  = m_tlast;
        if (levels_due.size() == 0) begin
          mismatches++;
          $display("%0t: band item with none expected: band %0d level %h last %b",
                   $time, got.band, got.level, got.last);
        end else begin
          want = levels_due.pop_front();
          if (got.band !== want.band || got.level !== want.level ||
              got.last !== want.last) begin
            mismatches++;
            $display("%0t: band item mismatch: expected band %0d level %h last %b,",
                     $time, want.band, want.level, want.last,
                     " got band %0d level %h last %b",
                     got.band, got.level, got.last);
          end
        end
      end
    end
    bands_pending <= levels_due.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Top of the spectrum_band_peak_scaler testbench: clock, reset, bin frames,
// config phases, m_axis pacing and the verdict.
// Depends on sbps_pkg, the block and sbps_band_checker.
module testbench
  import sbps_pkg::*;
();

  localparam int HOLD_CYCLES  = 1000;       // long m_axis hold-off
  localparam int SETTLE       = 150;        // > one linear band plus pipeline
  localparam int PHASE_MIN    = 20;         // bins per random phase, at least
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = 32'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  int mismatches;
  int bands_pending;

  // sender pacing: steady means back-to-back bins for the current frame
  bit sender_steady = 1'b0;
  int bins_sent = 0;
  // hold-off requests to the m_axis pacing process
  int holds_asked = 0;
  int holds_served = 0;

  always #5 clk = ~clk;

  spectrum_band_peak_scaler dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  sbps_band_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .bands_pending (bands_pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else if (r < 98)
      return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  // bin values: extremes, values around 1.0, and every leading-one position
  function automatic logic [31:0] pick_bin();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'd0;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h0000_FFFF + $urandom_range(0, 2);
      3:       v = $urandom_range(0, 255);
      4, 5, 6: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one bin item; valid stays high when the next item follows at once
  task automatic send_bin(input logic [31:0] value, input logic last);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bins_sent++;
  endtask

  task automatic send_frame(input int len);
    int i;
    for (i = 0; i < len; i++)
      send_bin(pick_bin(), i == len - 1);
  endtask

  // stop offering and wait until every band level has come out
  task automatic drain_bands();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bands_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_scaling(input logic mode, input logic [15:0] g);
    drain_bands();
    // upper bits of the mode write are don't-care
    write_reg(REG_LOG_MODE, {15'($urandom), mode});
    write_reg(REG_GAIN, g);
  endtask

  // m_axis pacing: random stalls, quiet stretches, and requested hold-offs
  initial begin : sink_pacing
    int stall_left;
    int run_left;
    bit steady;
    stall_left = 0;
    run_left = 0;
    steady = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        run_left = $urandom_range(100, 300);
      end
      run_left--;
      if (holds_asked != holds_served) begin
        holds_served = holds_asked;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int phase_start;
    int len;
    logic mode;
    logic [15:0] g;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset scaling (log, gain 1.0):
    // zero peak, full-scale peak, peak of exactly 1.0, just above 1.0,
    // peak below 1.0, then a flag inside band 5 drops the partial band.
    send_bin(32'h0000_0000, 1'b0);
    send_bin(32'hFFFF_FFFF, 1'b0);
    send_bin(32'h0001_0000, 1'b0);
    send_bin(32'h0001_0001, 1'b0);
    send_bin(32'h0000_8000, 1'b0);
    send_bin(32'h0000_0001, 1'b0);
    send_bin(32'h0000_FFFF, 1'b0);
    send_bin(32'h1234_5678, 1'b1);

    // linear at max gain: saturation, a zero peak, a one-LSB peak, and the
    // frame flag landing on the bin that closes a band
    set_scaling(1'b0, 16'hFFFF);
    send_bin(32'hFFFF_FFFF, 1'b0);
    send_bin(32'h0000_0000, 1'b0);
    send_bin(32'h0000_0001, 1'b0);
    send_bin(32'h00AB_CDEF, 1'b0);
    send_bin(32'hFFFF_FFFE, 1'b1);

    // log at zero gain, then one-bin frames
    set_scaling(1'b1, 16'h0000);
    send_bin(32'hFFFF_FFFF, 1'b0);
    send_bin(32'h0002_0000, 1'b1);
    send_bin(32'h7FFF_FFFF, 1'b1);
    send_bin(32'h8000_0000, 1'b1);

    // random phases over several scalings
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin mode = 1'b0; g = 16'd256;                      end
        1:       begin mode = 1'b1; g = 16'hFFFF;                     end
        2:       begin mode = 1'b0; g = 16'($urandom);                end
        3:       begin mode = 1'b1; g = 16'($urandom_range(1, 1024)); end
        default: begin mode = 1'b1; g = 16'($urandom);                end
      endcase
      set_scaling(mode, g);
      if (phase == 1) begin
        // receiver holds off while a full frame and the start of the next
        // pour in: more bands than the queue holds
        holds_asked++;
        sender_steady = 1'b1;
        send_frame(255 + $urandom_range(0, 3));
        send_frame($urandom_range(14, 20));
      end else begin
        phase_start = bins_sent;
        while (bins_sent - phase_start < PHASE_MIN) begin
          sender_steady = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 99) < 5)
            len = 255 + $urandom_range(0, 12);   // full frame, some bins past the table
          else
            len = $urandom_range(1, 40);         // short frame, partial band dropped
          send_frame(len);
          if ($urandom_range(0, 9) == 0)
            drain_bands();
        end
      end
    end

    drain_bands();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && bands_pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #TIMEOUT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule
